// ----- rtl/core/ordered_array_insert_erase_macros.svh -----
// Assertion macros for the ordered array control logic.
`ifndef ORDERED_ARRAY_INSERT_ERASE_MACROS_SVH
`define ORDERED_ARRAY_INSERT_ERASE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define OAIE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define OAIE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/core/oaie_pkg.sv -----
// Shared widths, command codes, status codes and cell operations for the ordered array.
package oaie_pkg;

  localparam int FUNC_W     = 3;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int RD_W       = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int WIDE_W     = 64;

  // position, range_end and value packed from bit 0, padded to whole bytes.
  localparam int S_TDATA_W  = ((POS_W + POS_W + VALUE_W + 7) / 8) * 8;
  // read_data and element_count packed from bit 0, padded to whole bytes.
  localparam int M_TDATA_W  = ((RD_W + COUNT_W + 7) / 8) * 8;

  localparam int DEFAULT_CAPACITY   = 16;
  localparam int DEFAULT_DATA_WIDTH = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH        = 3'd0,
    FUNC_POP         = 3'd1,
    FUNC_INSERT      = 3'd2,
    FUNC_ERASE       = 3'd3,
    FUNC_ERASE_RANGE = 3'd4,
    FUNC_READ        = 3'd5,
    FUNC_CLEAR       = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_op_e;

endpackage

// ----- rtl/core/oaie_cell.sv -----
// One storage cell of the array: holds, loads, or takes a neighbor's element.
module oaie_cell #(
  parameter int DATA_WIDTH = oaie_pkg::DEFAULT_DATA_WIDTH,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  oaie_pkg::cell_op_e    op_i,
  input  logic [IDX_W-1:0]      sel_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import oaie_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_LOAD: begin
        if (sel_i == MyIdx) data_d = wdata_i;
      end
      CELL_UP: begin
        // Insert: the cell at the position loads, cells above it move up by one.
        if (sel_i == MyIdx) begin
          data_d = wdata_i;
        end else if (MyIdx > sel_i) begin
          data_d = lower_i;
        end
      end
      CELL_DOWN: begin
        if (MyIdx >= sel_i) data_d = upper_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/core/oaie_ctrl.sv -----
// Command decoder, fill count, range-erase sequencer and result register.
module oaie_ctrl #(
  parameter int CAPACITY   = oaie_pkg::DEFAULT_CAPACITY,
  parameter int DATA_WIDTH = oaie_pkg::DEFAULT_DATA_WIDTH,
  parameter int IDX_W      = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [oaie_pkg::FUNC_W-1:0]      func_i,
  input  logic [oaie_pkg::POS_W-1:0]       position_i,
  input  logic [oaie_pkg::POS_W-1:0]       range_end_i,
  input  logic [oaie_pkg::VALUE_W-1:0]     value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [oaie_pkg::RD_W-1:0]        read_data_o,
  output logic [oaie_pkg::COUNT_W-1:0]     element_count_o,
  output logic [oaie_pkg::STATUS_W-1:0]    status_o,
  output oaie_pkg::cell_op_e               cell_op_o,
  output logic [IDX_W-1:0]                 cell_sel_o,
  output logic [DATA_WIDTH-1:0]            cell_wdata_o,
  output logic [IDX_W-1:0]                 rd_idx_o,
  input  logic [DATA_WIDTH-1:0]            rd_word_i
);
  import oaie_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SHIFT = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic                 out_valid_q;
  logic [RD_W-1:0]      out_rd_q;
  logic [CNT_W-1:0]     out_count_q;
  status_e              out_status_q;

  logic                 accept;
  logic                 done;
  status_e              stat;
  logic [RD_W-1:0]      rd;
  logic [CMP_W-1:0]     pos_c, rend_c, cnt_c, cap_c, gap_c;
  logic signed [DATA_WIDTH-1:0] rd_word_s;
  logic signed [WIDE_W-1:0]     rd_wide;

  assign pos_c  = CMP_W'(position_i);
  assign rend_c = CMP_W'(range_end_i);
  assign cnt_c  = CMP_W'(count_q);
  assign cap_c  = CMP_W'(CAPACITY);
  assign gap_c  = rend_c - pos_c;

  assign rd_idx_o     = IDX_W'(pos_c);
  assign rd_word_s    = rd_word_i;
  assign rd_wide      = WIDE_W'(rd_word_s);
  assign cell_wdata_o = DATA_WIDTH'(value_i);

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    cell_op_o = CELL_HOLD;
    cell_sel_o = '0;
    done      = 1'b0;
    stat      = STAT_OK;
    rd        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done = 1'b1;
          unique case (func_e'(func_i))
            FUNC_PUSH: begin
              if (cnt_c >= cap_c) begin
                stat = STAT_FULL;
              end else begin
                cell_op_o  = CELL_LOAD;
                cell_sel_o = IDX_W'(cnt_c);
                count_d    = count_q + 1'b1;
              end
            end
            FUNC_POP: begin
              if (count_q == '0) begin
                stat = STAT_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            FUNC_INSERT: begin
              if (pos_c > cnt_c) begin
                stat = STAT_RANGE;
              end else if (cnt_c >= cap_c) begin
                stat = STAT_FULL;
              end else begin
                cell_op_o  = CELL_UP;
                cell_sel_o = IDX_W'(pos_c);
                count_d    = count_q + 1'b1;
              end
            end
            FUNC_ERASE: begin
              if (pos_c >= cnt_c) begin
                stat = STAT_RANGE;
              end else begin
                cell_op_o  = CELL_DOWN;
                cell_sel_o = IDX_W'(pos_c);
                count_d    = count_q - 1'b1;
              end
            end
            FUNC_ERASE_RANGE: begin
              if (pos_c > rend_c || rend_c > cnt_c) begin
                stat = STAT_RANGE;
              end else if (gap_c != '0) begin
                // A range is erased one single-step shift per cycle at its start.
                cell_op_o  = CELL_DOWN;
                cell_sel_o = IDX_W'(pos_c);
                count_d    = count_q - 1'b1;
                if (gap_c != CMP_W'(1)) begin
                  done    = 1'b0;
                  rem_d   = CNT_W'(gap_c - CMP_W'(1));
                  pos_d   = IDX_W'(pos_c);
                  state_d = ST_SHIFT;
                end
              end
            end
            FUNC_READ: begin
              if (pos_c >= cnt_c) begin
                stat = STAT_RANGE;
              end else begin
                rd = rd_wide[RD_W-1:0];
              end
            end
            FUNC_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        cell_op_o  = CELL_DOWN;
        cell_sel_o = pos_q;
        count_d    = count_q - 1'b1;
        rem_d      = rem_q - 1'b1;
        if (rem_q == CNT_W'(1)) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (done) begin
      out_rd_q     <= rd;
      out_count_q  <= count_d;
      out_status_q <= stat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_rd_q;
  assign element_count_o = COUNT_W'(out_count_q);
  assign status_o        = out_status_q;

`include "ordered_array_insert_erase_macros.svh"

  `OAIE_ASSERT(a_count_in_bounds, count_q <= CNT_W'(CAPACITY), "fill count above capacity")
  `OAIE_ASSERT(a_shift_has_work, (state_q == ST_SHIFT) |-> (rem_q != '0), "range shift with no steps left")
  `OAIE_ASSERT(a_shift_counts_down, (state_q == ST_SHIFT) |=> (count_q == $past(count_q) - 1'b1), "range shift did not drop one element")
  `OAIE_ASSERT_NEVER(a_no_result_in_shift, (state_q == ST_SHIFT) && out_valid_q, "result pending during range shift")
  `OAIE_ASSERT(a_result_count_current, out_valid_q |-> (out_count_q == count_q), "reported count differs from fill count")
  `OAIE_ASSERT(a_full_means_full, (out_valid_q && out_status_q == STAT_FULL) |-> (count_q == CNT_W'(CAPACITY)), "full status with room left")

endmodule

// ----- rtl/core/ordered_array_insert_erase.sv -----
// Ordered array of signed words with push, pop, insert, erase, read and clear.
//
// Commands arrive as beats on the s_axis channel: tuser carries the command
// code, tdata carries position, range end and the value to store. Each
// command returns exactly one beat on the m_axis channel with the read value
// (zero unless a good read), the element count after the command and a
// status code in tuser (ok, position out of range, full, empty).
// Storage is a row of CAPACITY cells; insert and erase shift every cell above
// the position by one place, all cells together.
// Timing: for all commands but a multi-element range erase, the result beat
// is registered and valid in the cycle after the command beat. A range erase
// shifts one place per cycle from the cycle its command beat is taken, and
// its result beat follows the last shift. Commands are taken back to back while
// results are drained, so throughput is one command per cycle outside range erases.
// A pending result beat holds the command side: while the receiver stalls,
// s_axis_tready_o stays low once the result register is full.
// Reset empties the array (count zero) and drops any pending result; the
// element cells themselves are not cleared, which is invisible since only
// entries below the count can be read.
module ordered_array_insert_erase #(
  parameter int CAPACITY   = oaie_pkg::DEFAULT_CAPACITY,
  parameter int DATA_WIDTH = oaie_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // position [4:0], range_end [9:5], value [41:10], zero padding above
  input  logic [oaie_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // func [2:0]
  input  logic [oaie_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // read_data [31:0], element_count [36:32], zero padding above
  output logic [oaie_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // status [1:0]
  output logic [oaie_pkg::STATUS_W-1:0]    m_axis_tuser_o
);
  import oaie_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cell_op_e              cell_op;
  logic [IDX_W-1:0]      cell_sel;
  logic [DATA_WIDTH-1:0] cell_wdata;
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [RD_W-1:0]       read_data;
  logic [COUNT_W-1:0]    element_count;

  oaie_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .func_i          (s_axis_tuser_i),
    .position_i      (s_axis_tdata_i[POS_W-1:0]),
    .range_end_i     (s_axis_tdata_i[2*POS_W-1:POS_W]),
    .value_i         (s_axis_tdata_i[2*POS_W+VALUE_W-1:2*POS_W]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .read_data_o     (read_data),
    .element_count_o (element_count),
    .status_o        (m_axis_tuser_o),
    .cell_op_o       (cell_op),
    .cell_sel_o      (cell_sel),
    .cell_wdata_o    (cell_wdata),
    .rd_idx_o        (rd_idx),
    .rd_word_i       (rd_word)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    // The end cells see themselves where a neighbor is missing.
    localparam int Lo = (g == 0) ? 0 : g - 1;
    localparam int Hi = (g == CAPACITY - 1) ? g : g + 1;

    oaie_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .sel_i   (cell_sel),
      .wdata_i (cell_wdata),
      .lower_i (cell_data[Lo]),
      .upper_i (cell_data[Hi]),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    rd_word = cell_data[0];
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_idx == IDX_W'(i)) rd_word = cell_data[i];
    end
  end

  assign m_axis_tdata_o = {{(M_TDATA_W - RD_W - COUNT_W){1'b0}}, element_count, read_data};

endmodule

// ----- tb/tb_ordered_array_insert_erase.sv -----
// Self-checking testbench for the ordered array: directed table, then random commands.
`timescale 1ns / 100ps

module tb_ordered_array_insert_erase;
  import oaie_pkg::*;

  localparam int ARRAY_DEPTH = 16;
  localparam int CELL_IDX_W = $clog2(ARRAY_DEPTH);
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 1290;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [RD_W-1:0]    rd;
    logic [COUNT_W-1:0] cnt;
    logic [STATUS_W-1:0] st;
  } array_result_t;

  // Rows with reps above one send their command with random values instead of val.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    rend;
    logic [VALUE_W-1:0]  val;
    logic [4:0]          reps;
    logic                typed;
    logic [RD_W-1:0]     rd;
    logic [COUNT_W-1:0]  cnt;
    logic [STATUS_W-1:0] st;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  logic [VALUE_W-1:0] model_cells [ARRAY_DEPTH];
  int unsigned model_fill;
  array_result_t pending_results [$];
  array_result_t oldest;
  int n_fail = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_READ,        5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  STAT_RANGE},
    '{FUNC_POP,         5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  STAT_EMPTY},
    '{FUNC_ERASE,       5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  STAT_RANGE},
    '{FUNC_ERASE_RANGE, 5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_UNUSED,      5'd9, 5'd3, 32'h1234,     5'd1,  1'b1, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_PUSH,        5'd0, 5'd0, 32'h7fffffff, 5'd1,  1'b1, 32'h0,        5'd1,  STAT_OK},
    '{FUNC_PUSH,        5'd0, 5'd0, 32'h80000000, 5'd1,  1'b1, 32'h0,        5'd2,  STAT_OK},
    '{FUNC_INSERT,      5'd0, 5'd0, 32'hffffffff, 5'd1,  1'b1, 32'h0,        5'd3,  STAT_OK},
    '{FUNC_INSERT,      5'd4, 5'd0, 32'h5,        5'd1,  1'b1, 32'h0,        5'd3,  STAT_RANGE},
    '{FUNC_READ,        5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'hffffffff, 5'd3,  STAT_OK},
    '{FUNC_READ,        5'd2, 5'd0, 32'h0,        5'd1,  1'b1, 32'h80000000, 5'd3,  STAT_OK},
    '{FUNC_READ,        5'd3, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd3,  STAT_RANGE},
    '{FUNC_INSERT,      5'd3, 5'd0, 32'h1,        5'd1,  1'b0, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_ERASE,       5'd1, 5'd0, 32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_ERASE_RANGE, 5'd2, 5'd1, 32'h0,        5'd1,  1'b1, 32'h0,        5'd3,  STAT_RANGE},
    '{FUNC_ERASE_RANGE, 5'd0, 5'd4, 32'h0,        5'd1,  1'b1, 32'h0,        5'd3,  STAT_RANGE},
    '{FUNC_ERASE_RANGE, 5'd1, 5'd1, 32'h0,        5'd1,  1'b1, 32'h0,        5'd3,  STAT_OK},
    '{FUNC_PUSH,        5'd0, 5'd0, 32'h0,        5'd13, 1'b0, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_PUSH,        5'd0, 5'd0, 32'h55,       5'd1,  1'b1, 32'h0,        5'd16, STAT_FULL},
    '{FUNC_INSERT,      5'd16, 5'd0, 32'h66,      5'd1,  1'b1, 32'h0,        5'd16, STAT_FULL},
    '{FUNC_READ,        5'd15, 5'd0, 32'h0,       5'd1,  1'b0, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_ERASE_RANGE, 5'd0, 5'd16, 32'h0,       5'd1,  1'b1, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_PUSH,        5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd1,  STAT_OK},
    '{FUNC_CLEAR,       5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  STAT_OK},
    '{FUNC_READ,        5'd0, 5'd0, 32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  STAT_RANGE}
  };

  ordered_array_insert_erase u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Applies one command to the shadow array and returns the result it should produce.
  task automatic predict_array_cmd(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                   input logic [POS_W-1:0] rend, input logic [VALUE_W-1:0] val,
                                   output array_result_t res);
    int unsigned gap;
    res = '0;
    res.st = STAT_OK;
    case (func)
      FUNC_PUSH: begin
        if (model_fill >= ARRAY_DEPTH) begin
          res.st = STAT_FULL;
        end else begin
          model_cells[CELL_IDX_W'(model_fill)] = val;
          model_fill++;
        end
      end
      FUNC_POP: begin
        if (model_fill == 0) res.st = STAT_EMPTY;
        else model_fill--;
      end
      FUNC_INSERT: begin
        if (pos > model_fill) begin
          res.st = STAT_RANGE;
        end else if (model_fill >= ARRAY_DEPTH) begin
          res.st = STAT_FULL;
        end else begin
          for (int i = model_fill; i > pos; i--) begin
            model_cells[CELL_IDX_W'(i)] = model_cells[CELL_IDX_W'(i-1)];
          end
          model_cells[pos[CELL_IDX_W-1:0]] = val;
          model_fill++;
        end
      end
      FUNC_ERASE: begin
        if (pos >= model_fill) begin
          res.st = STAT_RANGE;
        end else begin
          for (int i = pos; i + 1 < model_fill; i++) begin
            model_cells[CELL_IDX_W'(i)] = model_cells[CELL_IDX_W'(i+1)];
          end
          model_fill--;
        end
      end
      FUNC_ERASE_RANGE: begin
        if (pos > rend || rend > model_fill) begin
          res.st = STAT_RANGE;
        end else begin
          gap = rend - pos;
          for (int i = pos; i + gap < model_fill; i++) begin
            model_cells[CELL_IDX_W'(i)] = model_cells[CELL_IDX_W'(i+gap)];
          end
          model_fill -= gap;
        end
      end
      FUNC_READ: begin
        if (pos >= model_fill) res.st = STAT_RANGE;
        else res.rd = model_cells[pos[CELL_IDX_W-1:0]];
      end
      FUNC_CLEAR: model_fill = 0;
      default: ;
    endcase
    res.cnt = model_fill[COUNT_W-1:0];
  endtask

  // Offers one beat, holds it until the block takes it and queues its expected result.
  task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                          input logic [POS_W-1:0] rend, input logic [VALUE_W-1:0] val,
                          input logic typed, input array_result_t typed_res);
    array_result_t res;
    s_valid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {{(S_TDATA_W - 2*POS_W - VALUE_W){1'b0}}, val, rend, pos};
    do @(posedge clk_i); while (!s_ready);
    predict_array_cmd(func, pos, rend, val, res);
    if (typed) res = typed_res;
    pending_results = {pending_results, res};
  endtask

  task automatic sender_gap();
    int n_idle;
    n_idle = 0;
    while (n_idle < 20 && $urandom_range(99) < send_idle_pct) n_idle++;
    if (n_idle > 0) begin
      s_valid <= 1'b0;
      repeat (n_idle) @(posedge clk_i);
    end
  endtask

  // Mostly well-formed commands for the current fill, with some out-of-range noise.
  task automatic random_cmd(output logic [FUNC_W-1:0] func, output logic [POS_W-1:0] pos,
                            output logic [POS_W-1:0] rend, output logic [VALUE_W-1:0] val);
    int pick;
    int span;
    pick = $urandom_range(99);
    if (pick < 22) func = FUNC_PUSH;
    else if (pick < 34) func = FUNC_POP;
    else if (pick < 54) func = FUNC_INSERT;
    else if (pick < 66) func = FUNC_ERASE;
    else if (pick < 78) func = FUNC_ERASE_RANGE;
    else if (pick < 96) func = FUNC_READ;
    else if (pick < 98) func = FUNC_CLEAR;
    else func = FUNC_UNUSED;
    case ($urandom_range(9))
      0: val = 32'h80000000;
      1: val = 32'h7fffffff;
      2: val = 32'hffffffff;
      default: val = $urandom;
    endcase
    pos = '0;
    rend = '0;
    if ($urandom_range(99) < 15) begin
      pos = POS_W'($urandom_range(16));
      rend = POS_W'($urandom_range(16));
    end else if (func == FUNC_INSERT) begin
      pos = POS_W'($urandom_range(model_fill));
    end else if (func == FUNC_ERASE || func == FUNC_READ) begin
      pos = (model_fill > 0) ? POS_W'($urandom_range(model_fill - 1)) : '0;
    end else if (func == FUNC_ERASE_RANGE) begin
      pos = POS_W'($urandom_range(model_fill));
      span = int'(model_fill) - int'(pos);
      // Short ranges keep the multi-cycle erase cheap; now and then the whole tail goes.
      if ($urandom_range(19) == 0) rend = POS_W'(model_fill);
      else rend = pos + POS_W'($urandom_range((span < 3) ? span : 3));
    end
  endtask

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Long receiver hold-off, counted down in cycles once requested.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        n_fail++;
      end else begin
        oldest = pending_results.pop_front();
        if (m_tdata[RD_W-1:0] !== oldest.rd) begin
          $error("read_data: expected %h, got %h", oldest.rd, m_tdata[RD_W-1:0]);
          n_fail++;
        end
        if (m_tdata[RD_W +: COUNT_W] !== oldest.cnt) begin
          $error("element_count: expected %0d, got %0d", oldest.cnt, m_tdata[RD_W +: COUNT_W]);
          n_fail++;
        end
        if (m_tuser !== oldest.st) begin
          $error("status: expected %0d, got %0d", oldest.st, m_tuser);
          n_fail++;
        end
      end
    end
    if ((hold_req && !hold_done) || hold_left > 0) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rend;
    logic [VALUE_W-1:0] val;
    array_result_t typed_res;

    model_cells = '{default: '0};
    model_fill = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 54;
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        typed_res = '{rd: directed_rows[r].rd, cnt: directed_rows[r].cnt,
                      st: directed_rows[r].st};
        val = (directed_rows[r].reps > 1) ? $urandom : directed_rows[r].val;
        send_cmd(directed_rows[r].func, directed_rows[r].pos, directed_rows[r].rend, val,
                 directed_rows[r].typed, typed_res);
        sender_gap();
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 20;
      end else if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Long receiver hold-off while commands keep coming, so the block backs up.
      if (n == 2 * N_RANDOM / 3 + 100) hold_req <= 1'b1;
      random_cmd(func, pos, rend, val);
      send_cmd(func, pos, rend, val, 1'b0, '0);
      sender_gap();
    end
    s_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- ordered_array_insert_erase.f -----
+incdir+rtl/core
rtl/core/oaie_pkg.sv
rtl/core/oaie_cell.sv
rtl/core/oaie_ctrl.sv
rtl/core/ordered_array_insert_erase.sv
tb/tb_ordered_array_insert_erase.sv
